// ===== src/dfp_pkg.sv =====
// Shared types and constants for the decimal float packer.
package dfp_pkg;

	localparam int AMOUNT_W = 64;
	localparam int FIELD_W  = 6;
	localparam int EXPO_W   = 5;
	localparam int CHUNK_W  = 16;
	localparam int CHUNKS   = AMOUNT_W / CHUNK_W;
	localparam int CNT_W    = $clog2(CHUNKS);
	localparam int PART_W   = CHUNK_W + 4;
	localparam int PROD_W   = PART_W + 32;

	// Division by ten as multiplication by the rounded-up reciprocal scaled by 2^35.
	localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	// Most trailing decimal zeros a 64-bit value can carry.
	localparam logic [EXPO_W-1:0] EXPO_MAX = 5'd19;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_MANT_WIDE = 2'd1,
		STATUS_EXP_WIDE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_PACK
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic accept;
		logic pack;
	} cmd_t;

	typedef struct packed {
		logic in_zero;
		logic last_chunk;
		logic rem_zero;
		logic out_free;
	} sts_t;

endpackage

// ===== src/dfp_ctrl.sv =====
// Controller state machine sequencing the divide-by-ten loop and the output load.
module dfp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  dfp_pkg::sts_t sts,
	output dfp_pkg::cmd_t cmd
);

	dfp_pkg::ctl_state_t state_q;
	dfp_pkg::ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dfp_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_nxt = sts.in_zero ? dfp_pkg::ST_PACK : dfp_pkg::ST_DIV;
				end
			end
			dfp_pkg::ST_DIV: begin
				if (sts.last_chunk) begin
					state_nxt = dfp_pkg::ST_CHECK;
				end
			end
			dfp_pkg::ST_CHECK: begin
				state_nxt = sts.rem_zero ? dfp_pkg::ST_DIV : dfp_pkg::ST_PACK;
			end
			dfp_pkg::ST_PACK: begin
				if (sts.out_free) begin
					state_nxt = dfp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = dfp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			dfp_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			dfp_pkg::ST_DIV: begin
				cmd.step = 1'b1;
			end
			dfp_pkg::ST_CHECK: begin
				cmd.accept = sts.rem_zero;
			end
			dfp_pkg::ST_PACK: begin
				cmd.pack = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// A zero amount would divide forever, so it must never enter the loop.
	a_zero_skips_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfp_pkg::ST_IDLE && s_tvalid && sts.in_zero)
			|=> (state_q == dfp_pkg::ST_PACK))
		else $error("zero amount entered the division loop");

	// The check state follows the last chunk step, with the chunk counter wrapped.
	a_check_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfp_pkg::ST_CHECK) |-> !sts.last_chunk)
		else $error("chunk counter did not wrap before the remainder check");

endmodule

// ===== src/dfp_datapath.sv =====
// Datapath: chunked divide-by-ten unit, zero count, field checks and output register.
module dfp_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dfp_pkg::cmd_t                  cmd,
	input  logic [dfp_pkg::AMOUNT_W-1:0]   amount,
	input  logic [dfp_pkg::FIELD_W-1:0]    mantissa_bits,
	input  logic [dfp_pkg::FIELD_W-1:0]    exponent_bits,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [dfp_pkg::AMOUNT_W-1:0]   packed_res,
	output dfp_pkg::status_t               status,
	output dfp_pkg::sts_t                  sts
);

	logic [dfp_pkg::AMOUNT_W-1:0] mant_q;
	logic [dfp_pkg::AMOUNT_W-1:0] quot_q;
	logic [dfp_pkg::FIELD_W-1:0]  mbits_q;
	logic [dfp_pkg::FIELD_W-1:0]  ebits_q;
	logic [dfp_pkg::EXPO_W-1:0]   expo_q;
	logic [3:0]                   rem_q;
	logic [dfp_pkg::CNT_W-1:0]    cnt_q;
	logic                         m_valid_q;
	logic [dfp_pkg::AMOUNT_W-1:0] packed_q;
	dfp_pkg::status_t             status_q;

	logic [dfp_pkg::CHUNK_W-1:0]  chunk;
	logic [dfp_pkg::PART_W-1:0]   part;
	logic [dfp_pkg::PROD_W-1:0]   prod;
	logic [dfp_pkg::CHUNK_W-1:0]  q_digit;
	logic [dfp_pkg::PART_W-1:0]   part_rem;

	logic                         mant_wide;
	logic                         exp_wide;
	logic [dfp_pkg::AMOUNT_W-1:0] shifted;
	logic [dfp_pkg::AMOUNT_W-1:0] res_nxt;
	dfp_pkg::status_t             status_nxt;

	// Long division from the top chunk down: remainder times 2^16 plus the next chunk.
	always_comb begin
		chunk    = mant_q[{~cnt_q, 4'b0000} +: dfp_pkg::CHUNK_W];
		part     = {rem_q, chunk};
		prod     = dfp_pkg::PROD_W'(part) * dfp_pkg::PROD_W'(dfp_pkg::RECIP10);
		q_digit  = prod[dfp_pkg::RECIP_SHIFT +: dfp_pkg::CHUNK_W];
		part_rem = part - {q_digit, 3'b000} - {2'b00, q_digit, 1'b0};
	end

	// Zero amount falls out here as zero with an OK status.
	always_comb begin
		mant_wide = (mant_q >> mbits_q) != '0;
		exp_wide  = (expo_q >> ebits_q) != '0;
		shifted   = mant_q << ebits_q;
		if (mant_wide) begin
			res_nxt    = '0;
			status_nxt = dfp_pkg::STATUS_MANT_WIDE;
		end else if (exp_wide) begin
			res_nxt    = shifted;
			status_nxt = dfp_pkg::STATUS_EXP_WIDE;
		end else begin
			res_nxt    = shifted | dfp_pkg::AMOUNT_W'(expo_q);
			status_nxt = dfp_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rem_q     <= '0;
			expo_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q  <= '0;
				rem_q  <= '0;
				expo_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
				rem_q <= part_rem[3:0];
			end else if (cmd.accept) begin
				rem_q  <= '0;
				expo_q <= expo_q + 1'b1;
			end
			if (cmd.pack) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mant_q  <= amount;
			mbits_q <= mantissa_bits;
			ebits_q <= exponent_bits;
		end else if (cmd.accept) begin
			mant_q <= quot_q;
		end
		if (cmd.step) begin
			quot_q <= {quot_q[dfp_pkg::AMOUNT_W-dfp_pkg::CHUNK_W-1:0], q_digit};
		end
		if (cmd.pack) begin
			packed_q <= res_nxt;
			status_q <= status_nxt;
		end
	end

	always_comb begin
		sts.in_zero    = amount == '0;
		sts.last_chunk = cnt_q == dfp_pkg::CNT_W'(dfp_pkg::CHUNKS - 1);
		sts.rem_zero   = rem_q == '0;
		sts.out_free   = !m_valid_q || m_tready;
	end

	assign m_tvalid   = m_valid_q;
	assign packed_res = packed_q;
	assign status     = status_q;

	a_expo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		expo_q <= dfp_pkg::EXPO_MAX)
		else $error("zero count exceeded nineteen");

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (mant_q != '0))
		else $error("division step on a zero mantissa");

	a_pack_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(packed_res))
		else $error("pending result overwritten");

endmodule

// ===== src/decimal_float_packer_top.sv =====
// Top level of the decimal float packer: stream ports, controller and datapath.
//
//  channel  dir  payload (low bits first)                          width
//  s_*      in   amount[63:0], mantissa_bits[5:0], exponent_bits    80
//  m_*      out  packed_res[63:0], status[1:0]                      72
//
// An input transfer is taken only while the controller is idle; a zero amount
// skips the division loop and goes straight to the pack step.
// A nonzero amount with z trailing decimal zeros reaches the output register
// through the pack step after z+1 tried divisions: each divide by ten is
// four 16-bit chunk steps on one shared multiplier plus a remainder check.
// The output register lets the next transfer in while a result waits; a
// stalled output holds the controller in its pack step. arst_n clears all control state.
module decimal_float_packer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // amount[63:0], mantissa_bits[69:64], exponent_bits[75:70]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata   // packed_res[63:0], status[65:64]
);

	dfp_pkg::cmd_t                 cmd;
	dfp_pkg::sts_t                 sts;
	logic [dfp_pkg::AMOUNT_W-1:0]  packed_res;
	dfp_pkg::status_t              status;

	dfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dfp_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.amount        (s_tdata[63:0]),
		.mantissa_bits (s_tdata[69:64]),
		.exponent_bits (s_tdata[75:70]),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.packed_res    (packed_res),
		.status        (status),
		.sts           (sts)
	);

	assign m_tdata = {6'd0, status, packed_res};

endmodule

// ===== verif/decimal_float_packer_top_tb.sv =====
// Self-checking testbench for the decimal float packer: directed and random stream traffic.
`timescale 1ns / 100ps

module decimal_float_packer_top_tb;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1280;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 400;

	typedef struct packed {
		logic [63:0]      code;
		dfp_pkg::status_t status;
	} pack_result_t;

	class code_checker;
		pack_result_t waiting[$];
		int           mismatches;
		int           taken;
		int           checked;
		int           n_ok;
		int           n_mant_wide;
		int           n_exp_wide;
		int           n_zero;

		function int bit_len(logic [63:0] v);
			int n;
			n = 0;
			while (v != 0) begin
				n++;
				v = v >> 1;
			end
			return n;
		endfunction

		// Strips trailing decimal zeros and packs mantissa over exponent.
		function pack_result_t pack_amount(logic [63:0] amount, logic [5:0] mb, logic [5:0] eb);
			logic [63:0]  mant;
			logic [63:0]  expo;
			pack_result_t r;
			mant     = amount;
			expo     = '0;
			r.code   = '0;
			r.status = dfp_pkg::STATUS_OK;
			if (amount == 0)
				return r;
			while (mant % 10 == 0) begin
				mant = mant / 10;
				expo++;
			end
			if (bit_len(mant) > mb) begin
				r.status = dfp_pkg::STATUS_MANT_WIDE;
				return r;
			end
			r.code = mant << eb;
			if (bit_len(expo) > eb)
				r.status = dfp_pkg::STATUS_EXP_WIDE;
			else
				r.code = r.code | expo;
			return r;
		endfunction

		function void note_amount(logic [63:0] amount, logic [5:0] mb, logic [5:0] eb);
			pack_result_t r;
			r = pack_amount(amount, mb, eb);
			waiting.push_back(r);
			taken++;
			if (amount == 0)
				n_zero++;
			case (r.status)
				dfp_pkg::STATUS_MANT_WIDE: n_mant_wide++;
				dfp_pkg::STATUS_EXP_WIDE:  n_exp_wide++;
				default:                   n_ok++;
			endcase
		endfunction

		function void check_code(logic [71:0] word);
			pack_result_t     want;
			dfp_pkg::status_t got_status;
			got_status = dfp_pkg::status_t'(word[65:64]);
			checked++;
			if (waiting.size() == 0) begin
				$error("unexpected result: packed_res=%h status=%0d", word[63:0], word[65:64]);
				mismatches++;
				return;
			end
			want = waiting.pop_front();
			if (word[63:0] !== want.code) begin
				$error("packed_res: expected %h, got %h", want.code, word[63:0]);
				mismatches++;
			end
			if (got_status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, word[65:64]);
				mismatches++;
			end
		endfunction

		function int pending();
			return waiting.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;

	code_checker board;
	bit          calm;
	int          hold_left;
	bit          hold_done;
	int          cycle_count;

	always #4 clk = ~clk;

	decimal_float_packer_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Receiver: random back-pressure, plus one long hold-off once traffic is under way.
	always @(posedge clk) begin
		bit ready_next;
		if (hold_left > 0) begin
			ready_next = 1'b0;
			hold_left--;
		end else if (!hold_done && board != null && board.taken >= HOLD_AFTER) begin
			hold_done  = 1'b1;
			hold_left  = HOLD_CYCLES - 1;
			ready_next = 1'b0;
		end else begin
			ready_next = calm || ($urandom_range(99) >= 37);
		end
		m_tready <= ready_next;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_code(m_tdata);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles with %0d results outstanding",
				cycle_count, board.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_item(input logic [63:0] amount, input logic [5:0] mb,
			input logic [5:0] eb);
		while (!calm && $urandom_range(99) < 37) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, eb, mb, amount};
		do @(posedge clk); while (!s_tready);
		board.note_amount(amount, mb, eb);
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [63:0] pow10(int z);
		logic [63:0] p;
		p = 64'd1;
		for (int k = 0; k < z; k++)
			p = p * 10;
		return p;
	endfunction

	task automatic random_item();
		int          total;
		int          len;
		int          sel;
		logic [63:0] mant;
		logic [63:0] amount;
		logic [5:0]  mb;
		logic [5:0]  eb;
		if ($urandom_range(99) < 70) begin
			// Widths that fill whole bytes, as real use would pick them.
			total = 8 * $urandom_range(1, 8);
			mb    = 6'($urandom_range(1, total - 1));
			eb    = 6'(total - mb);
		end else begin
			mb = 6'($urandom_range(0, 63));
			eb = 6'($urandom_range(0, 63));
		end
		sel = $urandom_range(99);
		if (sel < 3) begin
			amount = '0;
		end else if (sel < 50) begin
			len  = ($urandom_range(99) < 70 && mb != 0) ? $urandom_range(1, mb)
				: $urandom_range(1, 64);
			mant = {$urandom, $urandom} >> (64 - len);
			mant[len-1] = 1'b1;
			amount = mant * pow10($urandom_range(0, 19));
		end else if (sel < 65) begin
			amount = 64'($urandom_range(1, 100000));
		end else begin
			amount = {$urandom, $urandom};
		end
		send_item(amount, mb, eb);
	endtask

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero amounts, extreme values and every status path.
		send_item(64'd0, 6'd32, 6'd32);
		send_item(64'd0, 6'd0, 6'd0);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 6'd1);
		send_item(64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 6'd63);
		send_item(64'd1, 6'd1, 6'd63);
		send_item(64'd10000000000000000000, 6'd1, 6'd5);
		send_item(64'd10000000000000000000, 6'd1, 6'd4);
		send_item(64'd5, 6'd0, 6'd8);
		send_item(64'd100, 6'd1, 6'd0);
		send_item(64'd7, 6'd3, 6'd0);
		send_item(64'd12345000, 6'd32, 6'd32);
		send_item(64'd8, 6'd3, 6'd5);
		send_item(64'd7000, 6'd3, 6'd5);
		send_item(64'h7FFF_FFFF_FFFF_FFFF, 6'd63, 6'd63);
		send_item(64'd18446744073709551610, 6'd61, 6'd3);
		send_item(64'd250, 6'd5, 6'd2);
		send_item(64'd1, 6'd63, 6'd63);
		send_item(64'd9, 6'd4, 6'd4);
		send_item(64'd1000000, 6'd63, 6'd0);
		send_item(64'h8000_0000_0000_0000, 6'd63, 6'd1);
		send_item(64'd1000000000000000000, 6'd8, 6'd8);
		drain();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 500 && i < 700);
			if (i == 900)
				drain();
			random_item();
		end
		calm = 1'b0;
		drain();
		repeat (110) @(posedge clk);

		$display("Sent %0d amounts (%0d zero); predicted %0d ok,", board.taken,
			board.n_zero, board.n_ok);
		$display("%0d mantissa overflow, %0d exponent overflow; checked %0d results,",
			board.n_mant_wide, board.n_exp_wide, board.checked);
		$display("%0d mismatches in %0d cycles.", board.mismatches, cycle_count);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
